FILE: hdl/psc_pkg.sv
// Shared types, constants and fixed-point helpers of the PID speed controller.
package psc_pkg;

  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int SPEED_W  = 16;
  localparam int ERR_W    = 17;
  localparam int GAIN_W   = 32;
  localparam int BIAS_W   = 16;
  localparam int LIMIT_W  = 16;
  localparam int DUTY_W   = 16;
  localparam int Q_W      = 48;
  localparam int Q_FRAC   = 24;
  localparam int DIFF_W   = 49;
  localparam int SUM_W    = 50;
  localparam int SPEED_FRAC = 6;
  localparam int SMALL_BASE = Q_FRAC - SPEED_FRAC;

  typedef logic signed [ERR_W-1:0]  err_t;
  typedef logic signed [Q_W-1:0]    q_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [63:0]       wide_t;

  typedef enum logic [2:0] {
    REG_OUT_MIN,
    REG_OUT_MAX,
    REG_PROP_GAIN,
    REG_INTEG_GAIN,
    REG_DERIV_GAIN,
    REG_DERIV_POLE,
    REG_WINDUP_GAIN,
    REG_OUTPUT_BIAS
  } reg_idx_t;

  typedef struct packed {
    logic        [LIMIT_W-1:0] out_min;
    logic        [LIMIT_W-1:0] out_max;
    logic signed [GAIN_W-1:0]  prop_gain;
    logic signed [GAIN_W-1:0]  integ_gain;
    logic signed [GAIN_W-1:0]  deriv_gain;
    logic signed [GAIN_W-1:0]  deriv_pole;
    logic signed [GAIN_W-1:0]  windup_gain;
    logic signed [BIAS_W-1:0]  output_bias;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    out_min:     16'd159,
    out_max:     16'd318,
    prop_gain:   -32'sd144100,
    integ_gain:  32'sd93114,
    deriv_gain:  32'sd179013,
    deriv_pole:  32'sd2270560,
    windup_gain: 32'sd6710886,
    output_bias: 16'sd158
  };

  localparam wide_t SAT_HI  = 64'sh0000_7FFF_FFFF_FFFF;
  localparam wide_t SAT_LO  = 64'shFFFF_8000_0000_0000;
  localparam wide_t HB_HI   = 64'sh0001_0000_0000_0000;
  localparam wide_t HB_LO   = 64'shFFFF_0000_0000_0000;

  // Saturates a wide signed value to the 48-bit internal range.
  function automatic q_t sat48(wide_t x);
    q_t res;
    if (x > SAT_HI) begin
      res = q_t'(SAT_HI);
    end else if (x < SAT_LO) begin
      res = q_t'(SAT_LO);
    end else begin
      res = x[Q_W-1:0];
    end
    return res;
  endfunction

  // Gain times a Q.6 error-sized value, floored to Q24.24 and saturated.
  function automatic q_t mul_small(err_t e, logic signed [GAIN_W-1:0] g, int fb);
    logic signed [ERR_W+GAIN_W-1:0] prod;
    wide_t wide;
    prod = e * g;
    wide = {{(64-ERR_W-GAIN_W){prod[ERR_W+GAIN_W-1]}}, prod};
    if (fb >= SMALL_BASE) begin
      wide = wide >>> (fb - SMALL_BASE);
    end else begin
      wide = wide <<< (SMALL_BASE - fb);
    end
    return sat48(wide);
  endfunction

  // Gain times a Q24.24 value of up to 49 bits, split into an upper and a
  // lower partial product, floored and saturated.
  function automatic q_t mul_wide(diff_t a, logic signed [GAIN_W-1:0] g, int fb);
    logic signed [DIFF_W-Q_FRAC-1:0]       h;
    logic signed [Q_FRAC:0]                l;
    logic signed [DIFF_W-Q_FRAC+GAIN_W-1:0] hp;
    logic signed [Q_FRAC+GAIN_W:0]         lp;
    wide_t hb;
    wide_t lb;
    wide_t acc;
    h  = a[DIFF_W-1:Q_FRAC];
    l  = {1'b0, a[Q_FRAC-1:0]};
    hp = h * g;
    lp = l * g;
    hb = {{(64-DIFF_W+Q_FRAC-GAIN_W){hp[DIFF_W-Q_FRAC+GAIN_W-1]}}, hp};
    lb = {{(64-Q_FRAC-GAIN_W-1){lp[Q_FRAC+GAIN_W]}}, lp};
    if (fb <= Q_FRAC) begin
      if (hb > HB_HI) begin
        acc = SAT_HI;
      end else if (hb < HB_LO) begin
        acc = SAT_LO;
      end else begin
        acc = (hb <<< (Q_FRAC - fb)) + (lb >>> fb);
      end
    end else begin
      acc = (hb + (lb >>> Q_FRAC)) >>> (fb - Q_FRAC);
    end
    return sat48(acc);
  endfunction

endpackage

FILE: hdl/psc_regs.sv
// Configuration register file with an APB-style access port.
module psc_regs import psc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RST;
    end else if (wr) begin
      case (idx)
        REG_OUT_MIN:     cfg.out_min     <= pwdata[LIMIT_W-1:0];
        REG_OUT_MAX:     cfg.out_max     <= pwdata[LIMIT_W-1:0];
        REG_PROP_GAIN:   cfg.prop_gain   <= pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN:  cfg.integ_gain  <= pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN:  cfg.deriv_gain  <= pwdata[GAIN_W-1:0];
        REG_DERIV_POLE:  cfg.deriv_pole  <= pwdata[GAIN_W-1:0];
        REG_WINDUP_GAIN: cfg.windup_gain <= pwdata[GAIN_W-1:0];
        REG_OUTPUT_BIAS: cfg.output_bias <= pwdata[BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_OUT_MIN:     prdata = {{(DATA_W-LIMIT_W){1'b0}}, cfg.out_min};
      REG_OUT_MAX:     prdata = {{(DATA_W-LIMIT_W){1'b0}}, cfg.out_max};
      REG_PROP_GAIN:   prdata = cfg.prop_gain;
      REG_INTEG_GAIN:  prdata = cfg.integ_gain;
      REG_DERIV_GAIN:  prdata = cfg.deriv_gain;
      REG_DERIV_POLE:  prdata = cfg.deriv_pole;
      REG_WINDUP_GAIN: prdata = cfg.windup_gain;
      REG_OUTPUT_BIAS: prdata = {{(DATA_W-BIAS_W){1'b0}}, cfg.output_bias};
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: hdl/psc_core.sv
// Pipelined PID datapath with derivative filter and back-calculation windup.
module psc_core import psc_pkg::*; #(
  parameter int GAIN_FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SPEED_W-1:0] in_ref,
  input  logic [SPEED_W-1:0] in_meas,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DUTY_W-1:0]  out_duty,
  output logic               out_clamped
);

  logic v0, v1, v2, v3;
  logic rdy0, rdy1, rdy2, rdy3, rdy4;
  logic mv1, mv2, mv3, mv4;

  logic [SPEED_W-1:0] ref_spd, meas_spd;
  q_t   p_s1, iprod_s1, dprod_s1;
  q_t   p_s2, integ_s2, deriv_s2;
  sum_t sum_s3;

  err_t               last_error;
  logic [SPEED_W-1:0] last_measure;
  q_t                 integral_acc, deriv_term, windup_term;
  diff_t              last_diff;

  err_t  err, dmeas;
  q_t    p_next, iprod_next, dprod_next;
  q_t    integ_next, deriv_next;
  sum_t  sum_next;
  q_t    raw, u, lo, hi, windup_next;
  logic  lim;

  // Each stage moves on when it is empty or the next stage can take its word.
  assign rdy4     = !out_valid | out_ready;
  assign rdy3     = !v3 | rdy4;
  assign rdy2     = !v2 | rdy3;
  assign rdy1     = !v1 | rdy2;
  assign rdy0     = !v0 | rdy1;
  assign in_ready = !rst & rdy0;

  assign mv1 = v0 & rdy1;
  assign mv2 = v1 & rdy2;
  assign mv3 = v2 & rdy3;
  assign mv4 = v3 & rdy4;

  always_comb begin
    err        = $signed({1'b0, ref_spd}) - $signed({1'b0, meas_spd});
    dmeas      = $signed({1'b0, meas_spd}) - $signed({1'b0, last_measure});
    p_next     = mul_small(err, cfg.prop_gain, GAIN_FRAC_BITS);
    iprod_next = mul_small(last_error, cfg.integ_gain, GAIN_FRAC_BITS);
    dprod_next = mul_small(dmeas, cfg.deriv_gain, GAIN_FRAC_BITS);
  end

  always_comb begin
    integ_next = sat48(64'(integral_acc) + 64'(iprod_s1));
    deriv_next = sat48(64'(mul_wide(diff_t'(deriv_term), cfg.deriv_pole, GAIN_FRAC_BITS))
                       + 64'(dprod_s1));
  end

  assign sum_next = sum_t'(p_s2) + sum_t'(integ_s2) + sum_t'(deriv_s2)
                  + (sum_t'(cfg.output_bias) <<< Q_FRAC);

  always_comb begin
    lo  = q_t'({cfg.out_min, {Q_FRAC{1'b0}}});
    hi  = q_t'({cfg.out_max, {Q_FRAC{1'b0}}});
    raw = sat48(64'(sum_s3) + 64'(windup_term));
    lim = 1'b1;
    if (raw > hi) begin
      u = hi;
    end else if (raw < lo) begin
      u = lo;
    end else begin
      u   = raw;
      lim = 1'b0;
    end
    windup_next = sat48(64'(windup_term)
                        + 64'(mul_wide(last_diff, cfg.windup_gain, GAIN_FRAC_BITS)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0           <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      out_valid    <= 1'b0;
      last_error   <= '0;
      last_measure <= '0;
      integral_acc <= '0;
      deriv_term   <= '0;
      windup_term  <= '0;
      last_diff    <= '0;
    end else begin
      if (rdy0) begin
        v0 <= in_valid;
      end
      if (rdy1) begin
        v1 <= v0;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        out_valid <= v3;
      end
      if (mv1) begin
        last_error   <= err;
        last_measure <= meas_spd;
      end
      if (mv2) begin
        integral_acc <= integ_next;
        deriv_term   <= deriv_next;
      end
      if (mv4) begin
        windup_term <= windup_next;
        last_diff   <= diff_t'(u) - diff_t'(raw);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid & in_ready) begin
      ref_spd  <= in_ref;
      meas_spd <= in_meas;
    end
    if (mv1) begin
      p_s1     <= p_next;
      iprod_s1 <= iprod_next;
      dprod_s1 <= dprod_next;
    end
    if (mv2) begin
      p_s2     <= p_s1;
      integ_s2 <= integ_next;
      deriv_s2 <= deriv_next;
    end
    if (mv3) begin
      sum_s3 <= sum_next;
    end
    if (mv4) begin
      out_duty    <= u[Q_FRAC+DUTY_W-1:Q_FRAC];
      out_clamped <= lim;
    end
  end

endmodule

FILE: hdl/pid_speed_controller_antiwindup.sv
// Top level of the PID speed controller with back-calculation anti-windup.
//
//   Channel   Direction  Handshake                       Contents
//   s_*       in         s_tvalid / s_tready             one speed sample word
//   m_*       out        m_tvalid / m_tready             one duty word
//   APB       in         psel, penable, pwrite, pready   eight control registers
//
// A word is accepted in every cycle unless m_tready stalls the pipeline;
// results pass input, product, term, sum and output registers. The derivative
// filter update (two 25x32 partial products and a saturating add) is the
// longest path. Reset clears controller state and restores register defaults.
// When m_tready is low the pipeline keeps filling and holds up to five words.
module pid_speed_controller_antiwindup import psc_pkg::*; #(
  parameter int GAIN_FRAC_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [31:0]       s_tdata,   // reference_speed [15:0], measured_speed [31:16]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,   // drive_duty [15:0]
  output logic              m_tuser    // clamped [0]
);

  cfg_t cfg;

  psc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  psc_core #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_ref      (s_tdata[SPEED_W-1:0]),
    .in_meas     (s_tdata[2*SPEED_W-1:SPEED_W]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_duty    (m_tdata),
    .out_clamped (m_tuser)
  );

endmodule

FILE: hdl/psc_checker.sv
// Port-level assertions for the PID speed controller, bound to the top level.
module psc_checker import psc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic [DATA_W-1:0] prdata,
  input logic              pready,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [15:0]       m_tdata,
  input logic              m_tuser
);

  // No sample may be taken while reset is applied.
  a_no_accept_in_reset: assert property (@(posedge clk) rst |-> !s_tready)
    else $error("sample accepted during reset");

  // A result needs the full pipeline depth after reset.
  a_fill_latency: assert property (@(posedge clk) $past(rst, 4) |-> !m_tvalid)
    else $error("result word appeared before the pipeline could fill");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result word changed");

  // A full-width gain register reads back what was last written to it.
  a_gain_readback: assert property (@(posedge clk) disable iff (rst)
    $past(psel && penable && pwrite && pready && !rst)
    && ($past(paddr[ADDR_W-1:2]) == REG_PROP_GAIN
        || $past(paddr[ADDR_W-1:2]) == REG_INTEG_GAIN
        || $past(paddr[ADDR_W-1:2]) == REG_DERIV_GAIN
        || $past(paddr[ADDR_W-1:2]) == REG_DERIV_POLE
        || $past(paddr[ADDR_W-1:2]) == REG_WINDUP_GAIN)
    && paddr[ADDR_W-1:2] == $past(paddr[ADDR_W-1:2])
    |-> prdata == $past(pwdata))
    else $error("gain register read back a different value");

endmodule

bind pid_speed_controller_antiwindup psc_checker u_psc_checker (.*);
